@@ hdl/cft_pkg.sv @@
// shared types and constants for the csv field tokenizer
`default_nettype none
package cft_pkg;

    localparam int LINE_BITS = 16;
    localparam int COL_BITS  = 8;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] SEP_RESET  = 8'd44;

    localparam logic [1:0] KIND_BYTE        = 2'd0;
    localparam logic [1:0] KIND_FIELD_END   = 2'd1;
    localparam logic [1:0] KIND_END_OF_TEXT = 2'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_QUOTED   = 2'd1,
        MODE_QSEEN    = 2'd2,
        MODE_LINE_END = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic                 has_bytes;
        logic [LINE_BITS-1:0] line_cnt;
        logic [COL_BITS-1:0]  col_cnt;
        logic [COL_BITS:0]    widest;
    } parse_state_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           kind;
        logic [7:0]           data;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        logic                 fin;
        logic [LINE_BITS-1:0] line_total;
        logic [COL_BITS:0]    col_total;
    } parse_result_t;

endpackage
`default_nettype wire

@@ hdl/cft_parse_core.sv @@
// next-state and result logic for one text item
`default_nettype none
module cft_parse_core (
    input  wire cft_pkg::parse_state_t  cur,
    input  wire logic [7:0]             text_byte,
    input  wire logic                   end_of_text,
    input  wire logic [7:0]             separator,
    output cft_pkg::parse_state_t       nxt,
    output cft_pkg::parse_result_t      res
);
    import cft_pkg::*;

    logic                 do_normal;
    logic                 is_eol;
    logic [COL_BITS:0]    col_plus;
    logic [COL_BITS:0]    widened;
    logic [LINE_BITS-1:0] line_sat;
    logic [COL_BITS-1:0]  col_sat;

    assign is_eol   = (text_byte == LF_BYTE) || (text_byte == CR_BYTE);
    assign col_plus = {1'b0, cur.col_cnt} + {{COL_BITS{1'b0}}, 1'b1};
    assign widened  = (cur.widest < col_plus) ? col_plus : cur.widest;
    assign line_sat = (cur.line_cnt != LINE_MAX) ? cur.line_cnt + 1'b1 : cur.line_cnt;
    assign col_sat  = (cur.col_cnt != COL_MAX) ? cur.col_cnt + 1'b1 : cur.col_cnt;

    always_comb
    begin
        nxt       = cur;
        res       = '0;
        do_normal = 1'b0;
        if (end_of_text)
        begin
            res.valid = 1'b1;
            res.kind  = KIND_END_OF_TEXT;
            if (cur.has_bytes)
            begin
                res.line       = cur.line_cnt;
                res.col        = cur.col_cnt;
                res.fin        = 1'b1;
                res.line_total = line_sat;
                res.col_total  = widened;
            end
            else
            begin
                res.line_total = cur.line_cnt;
                res.col_total  = cur.widest;
            end
            nxt = '0;
        end
        else
        begin
            unique case (cur.mode)
                MODE_QUOTED:
                begin
                    nxt.has_bytes = 1'b1;
                    if (text_byte == QUOTE_BYTE)
                        nxt.mode = MODE_QSEEN;
                    else
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_BYTE;
                        res.data  = text_byte;
                        res.line  = cur.line_cnt;
                        res.col   = cur.col_cnt;
                    end
                end
                MODE_QSEEN:
                begin
                    if (text_byte == QUOTE_BYTE)
                    begin
                        // doubled quote gives one literal quote
                        nxt.mode  = MODE_QUOTED;
                        res.valid = 1'b1;
                        res.kind  = KIND_BYTE;
                        res.data  = text_byte;
                        res.line  = cur.line_cnt;
                        res.col   = cur.col_cnt;
                    end
                    else
                        do_normal = 1'b1;
                end
                MODE_LINE_END:
                begin
                    // second byte of a cr/lf pair is swallowed
                    if (is_eol)
                        nxt.mode = MODE_NORMAL;
                    else
                        do_normal = 1'b1;
                end
                MODE_NORMAL:
                    do_normal = 1'b1;
            endcase

            if (do_normal)
            begin
                nxt.mode = MODE_NORMAL;
                priority if (text_byte == QUOTE_BYTE)
                begin
                    nxt.mode      = MODE_QUOTED;
                    nxt.has_bytes = 1'b1;
                end
                else if (text_byte == separator || is_eol)
                begin
                    res.valid     = 1'b1;
                    res.kind      = KIND_FIELD_END;
                    res.line      = cur.line_cnt;
                    res.col       = cur.col_cnt;
                    nxt.widest    = widened;
                    nxt.has_bytes = 1'b0;
                    if (text_byte == separator)
                        nxt.col_cnt = col_sat;
                    else
                    begin
                        nxt.line_cnt = line_sat;
                        nxt.col_cnt  = '0;
                        nxt.mode     = MODE_LINE_END;
                    end
                end
                else
                begin
                    nxt.has_bytes = 1'b1;
                    res.valid     = 1'b1;
                    res.kind      = KIND_BYTE;
                    res.data      = text_byte;
                    res.line      = cur.line_cnt;
                    res.col       = cur.col_cnt;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/csv_field_tokenizer_unit.sv @@
// csv field tokenizer top level: input register, parse state, result register
//
// input channel: text_byte / end_of_text, taken when in_valid is high and
// in_stall is low. output channel: one result item (content byte, field end
// or end of text) shown with out_valid, taken when out_stall is low.
// bytes that open or close quotes, and the second byte of a cr/lf pair,
// give no result item.
// the input register holds a taken item; its result is registered in the result
// register when that register is empty or not stalled, and out_valid rises if the item gives a result.
// throughput: one item per cycle while the receiver does not stall; the parse state
// updates in a single pass between the input register and the result register.
// while the receiver stalls, the result register holds and one more item
// waits in the input register; after that in_stall goes high.
// the user writes separator through cfg_we / cfg_data only while the block is idle,
// which the block does not enforce. reset: separator returns to a comma, the parse
// state and counters clear, and both registers are empty.
`default_nettype none
module csv_field_tokenizer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    text_byte,
    input  wire logic                          end_of_text,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         kind,
    output logic [7:0]                         out_byte,
    output logic [cft_pkg::LINE_BITS-1:0]      line_index,
    output logic [cft_pkg::COL_BITS-1:0]       column_index,
    output logic                               final_field,
    output logic [cft_pkg::LINE_BITS-1:0]      line_count,
    output logic [cft_pkg::COL_BITS:0]         column_count
);
    import cft_pkg::*;

    logic [7:0]    separator_reg;
    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_eot_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_next;
    logic          out_valid_reg;
    parse_result_t out_reg;
    logic          advance;
    logic          in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    cft_parse_core u_core (
        .cur         (state_reg),
        .text_byte   (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .separator   (separator_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEP_RESET;
            s1_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                separator_reg <= cfg_data;
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (s1_valid_reg && advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= s1_valid_reg && res_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= text_byte;
            s1_eot_reg  <= end_of_text;
        end
        if (advance)
            out_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign out_byte     = out_reg.data;
    assign line_index   = out_reg.line;
    assign column_index = out_reg.col;
    assign final_field  = out_reg.fin;
    assign line_count   = out_reg.line_total;
    assign column_count = out_reg.col_total;

endmodule
`default_nettype wire

@@ hdl/cft_checker.sv @@
// port-level checks for the csv field tokenizer, bound to the top level
`default_nettype none
module cft_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [7:0]                    out_byte,
    input  wire logic [cft_pkg::LINE_BITS-1:0] line_index,
    input  wire logic [cft_pkg::COL_BITS-1:0]  column_index,
    input  wire logic                          final_field,
    input  wire logic [cft_pkg::LINE_BITS-1:0] line_count,
    input  wire logic [cft_pkg::COL_BITS:0]    column_count
);
    import cft_pkg::*;

    // stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
            && $stable(line_index) && $stable(column_index))
        else $error("stalled result item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_BYTE || kind == KIND_FIELD_END
            || kind == KIND_END_OF_TEXT))
        else $error("result kind out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> out_byte == 8'd0)
        else $error("nonzero byte on a field or text end");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_END_OF_TEXT |->
            !final_field && line_count == '0 && column_count == '0)
        else $error("totals shown outside end of text");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END_OF_TEXT && !final_field |->
            line_index == '0 && column_index == '0)
        else $error("position given without a last field");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (.*);
`default_nettype wire

@@ dv/tb_csv_field_tokenizer_unit.sv @@
// testbench for csv_field_tokenizer_unit: directed and random text checked against a predictor
module tb_csv_field_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cft_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [7:0]           cfg_data = 8'h00;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           text_byte = 8'h00;
    logic                 end_of_text = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           kind;
    logic [7:0]           out_byte;
    logic [LINE_BITS-1:0] line_index;
    logic [COL_BITS-1:0]  column_index;
    logic                 final_field;
    logic [LINE_BITS-1:0] line_count;
    logic [COL_BITS:0]    column_count;

    csv_field_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .line_index   (line_index),
        .column_index (column_index),
        .final_field  (final_field),
        .line_count   (line_count),
        .column_count (column_count)
    );

    always #4 clk = ~clk;

    // predictor state, mirrors the tokenizer after reset
    mode_t                mode_q = MODE_NORMAL;
    logic                 has_bytes_q = 1'b0;
    logic [LINE_BITS-1:0] line_q = '0;
    logic [COL_BITS-1:0]  col_q = '0;
    logic [COL_BITS:0]    widest_q = '0;
    logic [7:0]           separator_model = SEP_RESET;

    parse_result_t expected_results[$];

    int sender_gap_pct = 0;
    int receiver_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int separators_tried = 0;

    function automatic parse_result_t located_result(logic [1:0] k, logic [7:0] d);
        parse_result_t r;
        r = '0;
        r.valid = 1'b1;
        r.kind = k;
        r.data = d;
        r.line = line_q;
        r.col = col_q;
        return r;
    endfunction

    function automatic void widen_columns();
        logic [COL_BITS:0] n;
        n = {1'b0, col_q} + 1'b1;
        if (widest_q < n)
            widest_q = n;
    endfunction

    function automatic parse_result_t close_field();
        parse_result_t r;
        r = located_result(KIND_FIELD_END, 8'h00);
        widen_columns();
        if (col_q != COL_MAX)
            col_q++;
        has_bytes_q = 1'b0;
        return r;
    endfunction

    function automatic parse_result_t unquoted_byte(logic [7:0] b);
        parse_result_t r;
        r = '0;
        mode_q = MODE_NORMAL;
        if (b == QUOTE_BYTE)
        begin
            mode_q = MODE_QUOTED;
            has_bytes_q = 1'b1;
        end
        else if (b == separator_model)
        begin
            r = close_field();
        end
        else if (b == LF_BYTE || b == CR_BYTE)
        begin
            r = close_field();
            if (line_q != LINE_MAX)
                line_q++;
            col_q = '0;
            mode_q = MODE_LINE_END;
        end
        else
        begin
            has_bytes_q = 1'b1;
            r = located_result(KIND_BYTE, b);
        end
        return r;
    endfunction

    function automatic parse_result_t tokenize_step(logic [7:0] b, logic eot);
        parse_result_t r;
        logic [LINE_BITS-1:0] lines;
        r = '0;
        if (eot)
        begin
            lines = line_q;
            r.valid = 1'b1;
            r.kind = KIND_END_OF_TEXT;
            if (has_bytes_q)
            begin
                widen_columns();
                if (lines != LINE_MAX)
                    lines++;
                r.line = line_q;
                r.col = col_q;
                r.fin = 1'b1;
            end
            r.line_total = lines;
            r.col_total = widest_q;
            mode_q = MODE_NORMAL;
            has_bytes_q = 1'b0;
            line_q = '0;
            col_q = '0;
            widest_q = '0;
        end
        else
        begin
            case (mode_q)
                MODE_QUOTED:
                begin
                    has_bytes_q = 1'b1;
                    if (b == QUOTE_BYTE)
                        mode_q = MODE_QSEEN;
                    else
                        r = located_result(KIND_BYTE, b);
                end
                MODE_QSEEN:
                begin
                    // doubled quote gives one quote byte
                    if (b == QUOTE_BYTE)
                    begin
                        mode_q = MODE_QUOTED;
                        r = located_result(KIND_BYTE, b);
                    end
                    else
                    begin
                        r = unquoted_byte(b);
                    end
                end
                MODE_LINE_END:
                begin
                    // second byte of a cr/lf pair is swallowed
                    if (b == LF_BYTE || b == CR_BYTE)
                        mode_q = MODE_NORMAL;
                    else
                        r = unquoted_byte(b);
                end
                default:
                begin
                    r = unquoted_byte(b);
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : predict_results
        parse_result_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            r = tokenize_step(text_byte, end_of_text);
            if (r.valid)
                expected_results.push_back(r);
        end
    end

    task automatic report_mismatch(input string what, input parse_result_t want,
                                   input parse_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected kind=%0d byte=%02h line=%0d col=%0d fin=%0d %0d %0d",
                     $realtime, what,
                     want.kind, want.data, want.line, want.col, want.fin,
                     want.line_total, want.col_total);
            $display("    got kind=%0d byte=%02h line=%0d col=%0d fin=%0d %0d %0d",
                     got.kind, got.data, got.line, got.col, got.fin,
                     got.line_total, got.col_total);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        parse_result_t got;
        parse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.valid = 1'b1;
            got.kind = kind;
            got.data = out_byte;
            got.line = line_index;
            got.col = column_index;
            got.fin = final_field;
            got.line_total = line_count;
            got.col_total = column_count;
            results_checked++;
            if (expected_results.size() == 0)
            begin
                want = '0;
                report_mismatch("unexpected item", want, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_mismatch("mismatch", want, got);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // items without a result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        wait_until_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        separator_model = value;
        separators_tried++;
    endtask

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == QUOTE_BYTE || b == LF_BYTE || b == CR_BYTE || b == separator_model);
        return b;
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(0, 4))
            0: return QUOTE_BYTE;
            1: return separator_model;
            2: return ($urandom_range(0, 1) != 0) ? LF_BYTE : CR_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_csv_field();
        int len;
        logic [7:0] b;
        len = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
        begin
            send_item(QUOTE_BYTE, 1'b0);
            repeat (len)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_item(QUOTE_BYTE, 1'b0);
                    send_item(QUOTE_BYTE, 1'b0);
                end
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == QUOTE_BYTE)
                        b = 8'h21;
                    send_item(b, 1'b0);
                end
            end
            send_item(QUOTE_BYTE, 1'b0);
        end
        else
        begin
            repeat (len) send_item(pick_plain_byte(), 1'b0);
        end
    endtask

    task automatic send_csv_record();
        int n_fields;
        n_fields = $urandom_range(1, 6);
        for (int f = 0; f < n_fields; f++)
        begin
            send_csv_field();
            if (f < n_fields - 1)
                send_item(separator_model, 1'b0);
        end
        case ($urandom_range(0, 4))
            0: send_item(LF_BYTE, 1'b0);
            1: send_item(CR_BYTE, 1'b0);
            2:
            begin
                send_item(CR_BYTE, 1'b0);
                send_item(LF_BYTE, 1'b0);
            end
            3:
            begin
                send_item(LF_BYTE, 1'b0);
                send_item(LF_BYTE, 1'b0);
                send_item(LF_BYTE, 1'b0);
            end
            default: ;
        endcase
    endtask

    task automatic test_directed_cases();
        logic [7:0] text[$];
        // quoted field with doubled quote, cr/lf pair, empty line, quote then other byte
        text = '{QUOTE_BYTE, "x", QUOTE_BYTE, QUOTE_BYTE, "y", QUOTE_BYTE, ",",
                 CR_BYTE, LF_BYTE, LF_BYTE, QUOTE_BYTE, "a", QUOTE_BYTE, "b"};
        foreach (text[i]) send_item(text[i], 1'b0);
        send_item(8'hA5, 1'b1);
        // text ends inside quotes
        send_item(QUOTE_BYTE, 1'b0);
        send_item("z", 1'b0);
        send_item(8'h5A, 1'b1);
        // nothing pending at end of text
        send_item(8'h00, 1'b1);
        text = '{8'h00, 8'hFF, ","};
        foreach (text[i]) send_item(text[i], 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_separator_values();
        logic [7:0] seps[$];
        logic [7:0] text[$];
        seps = '{QUOTE_BYTE, LF_BYTE, CR_BYTE, 8'h00, 8'hFF, ";", 8'($urandom_range(0, 255))};
        foreach (seps[s])
        begin
            write_separator(seps[s]);
            text = '{"a", seps[s], "b", QUOTE_BYTE, "c", QUOTE_BYTE, seps[s],
                     CR_BYTE, LF_BYTE, seps[s], "d"};
            foreach (text[i]) send_item(text[i], 1'b0);
            send_csv_record();
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic test_random_text(input int budget);
        int start;
        int pick;
        case ($urandom_range(0, 5))
            0: write_separator(";");
            1: write_separator(8'h09);
            2: write_separator("|");
            3: write_separator(8'($urandom_range(0, 255)));
            default: write_separator(",");
        endcase
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_csv_record();
            else if (pick < 9)
                repeat ($urandom_range(1, 8)) send_item(pick_noise_byte(), 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_output_hold_off();
        int start;
        hold_request = HOLD_OFF_CYCLES;
        start = items_sent;
        while (items_sent - start < 40)
            send_csv_record();
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_counter_saturation();
        write_separator(",");
        // column counter stops at its maximum, widest goes one past it
        repeat (260) send_item(",", 1'b0);
        send_item("q", 1'b0);
        send_item(8'h00, 1'b1);
        send_csv_record();
        send_item(8'h00, 1'b1);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gap_pct = 12;
        receiver_stall_pct = 62;
        test_directed_cases();
        test_separator_values();
        test_random_text(80);

        sender_gap_pct = 62;
        receiver_stall_pct = 12;
        test_random_text(80);

        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        test_output_hold_off();
        test_random_text(40);
        test_counter_saturation();

        wait_until_idle();
        if (expected_results.size() != 0)
        begin
            mismatch_count += expected_results.size();
            $display("%0d expected items never arrived", expected_results.size());
        end

        $display("run: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatch_count);
        $display("covered: quotes, line ends, %0d separators, hold-off, column saturation",
                 separators_tried);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
